/* rtl/scm_pkg.sv */
// Shared constants and types of the scope frame measurement block.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package scm_pkg;

   // Longest frame that is measured; the sample index saturates here.
   localparam int FRAME_MAX_DEF = 4096;

   // Measured index window for pulse tracking: WIN_FIRST up to WIN_END - 1.
   localparam int WIN_FIRST = 2;
   localparam int WIN_END   = 4094;

   // Hysteresis offsets: HYST_UP above the previous frame's midpoint, HYST_DOWN below the upper threshold.
   localparam logic [7:0] HYST_UP   = 8'd4;
   localparam logic [7:0] HYST_DOWN = 8'd8;

   // Configuration register indexes.
   localparam logic CSR_A_REF = 1'b0;
   localparam logic CSR_B_REF = 1'b1;

   // Channel codes of the result words.
   localparam logic [1:0] CH_A = 2'd0;
   localparam logic [1:0] CH_B = 2'd1;
   localparam logic [1:0] CH_C = 2'd2;
   localparam logic [1:0] CH_D = 2'd3;

   // Per-item control handed from the top level to the channel units.
   typedef struct packed {
      logic advance;    // the staged word is consumed this cycle
      logic frame_end;  // it closes the frame
      logic take;       // index below the frame limit: statistics are taken
      logic first;      // index zero: extremes are loaded, not compared
      logic track;      // index inside the pulse window
   } step_type;

   typedef struct packed {
      logic [7:0]  max_value;
      logic [7:0]  min_value;
      logic [19:0] sample_sum;
      logic [31:0] square_sum;
   } ana_stat_type;

   typedef struct packed {
      logic [11:0] edge_span;
      logic [11:0] high_time;
      logic [10:0] rising_edges;
   } pulse_stat_type;

   typedef struct packed {
      logic [1:0]  channel;
      logic [7:0]  max_value;
      logic [7:0]  min_value;
      logic [19:0] sample_sum;
      logic [31:0] square_sum;
      logic [11:0] edge_span;
      logic [11:0] high_time;
      logic [10:0] rising_edges;
      logic        last_of_run;
   } rsp_word_type;

endpackage

`default_nettype wire

/* rtl/scm_if.sv */
// Valid/ready channel interfaces of the scope frame measurement block.
// Sample words in, per-channel result words out; no dependencies.
`default_nettype none

interface scm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_a;
   logic [7:0] sample_b;
   logic [1:0] logic_bits;
   logic       frame_end;

   modport source (output valid, sample_a, sample_b, logic_bits, frame_end, input ready);
   modport sink   (input valid, sample_a, sample_b, logic_bits, frame_end, output ready);
endinterface

interface scm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  channel;
   logic [7:0]  max_value;
   logic [7:0]  min_value;
   logic [19:0] sample_sum;
   logic [31:0] square_sum;
   logic [11:0] edge_span;
   logic [11:0] high_time;
   logic [10:0] rising_edges;
   logic        last_of_run;

   modport source (output valid, channel, max_value, min_value, sample_sum, square_sum,
                   edge_span, high_time, rising_edges, last_of_run, input ready);
   modport sink   (input valid, channel, max_value, min_value, sample_sum, square_sum,
                   edge_span, high_time, rising_edges, last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/scope_frame_measurement.sv */
// Top level of the scope frame measurement block: input stage, channel units, result buffer.
// Depends on scm_pkg, scm_if, scm_analog and scm_pulse.
//
//   Channel   Direction  Handshake            Word
//   req_chan  in         valid/ready          sample_a, sample_b, logic_bits, frame_end
//   rsp_chan  out        valid/ready          one channel's frame results
//   csr_*     in         write enable only    a_reference (index 0), b_reference (index 1)
//
// A sample word is taken every cycle unless stalled. It is held in the input stage, where the
// squared deviations are already registered, and then folded into the frame statistics.
// A word that closes the frame loads four result words (A, B, C, D) into the result
// buffer, which drains one word per cycle while ready is high; the input only stalls when a second
// frame end reaches the input stage before the buffer has handed out its previous four words.
// Reset is synchronous; it clears the statistics, the thresholds and both references.
// Results are delivered in order however long the sink holds ready low.
`default_nettype none

module scope_frame_measurement
   import scm_pkg::*;
#(
   parameter int FRAME_MAX = FRAME_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   scm_req_if.sink    req_chan,
   scm_rsp_if.source  rsp_chan,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [9:0] csr_write_data
);

   localparam int IDX_W = $clog2(FRAME_MAX + 1);

   // Configuration registers.
   logic [9:0] a_ref_ff, b_ref_ff;

   // Input stage.
   logic        s1_valid_ff;
   logic [7:0]  s1_a_ff, s1_b_ff;
   logic [1:0]  s1_logic_ff;
   logic        s1_end_ff;
   logic [19:0] s1_sq_a_ff, s1_sq_b_ff;

   // Squared deviations from the reference, computed as the word enters.
   logic signed [10:0] dev_a, dev_b;
   logic signed [21:0] prod_a, prod_b;

   // Frame position and per-word control.
   logic [IDX_W-1:0] idx_ff;
   logic [11:0]      idx12;
   step_type         step;
   logic             req_fire, rsp_fire, snap_free;

   // Channel unit results.
   ana_stat_type   ana_stat   [2];
   pulse_stat_type pulse_stat [4];
   logic           ch_high    [4];
   logic           ch_low     [4];
   logic [7:0]     ana_sample [2];
   logic [19:0]    ana_square [2];

   // Result buffer.
   rsp_word_type snap_in [4];
   rsp_word_type snap_ff [4];
   logic         busy_ff;
   logic [1:0]   cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ref_ff <= '0;
         b_ref_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_A_REF: a_ref_ff <= csr_write_data;
            CSR_B_REF: b_ref_ff <= csr_write_data;
         endcase
      end
   end

   always_comb begin
      dev_a  = $signed({3'b000, req_chan.sample_a}) - $signed({a_ref_ff[9], a_ref_ff});
      dev_b  = $signed({3'b000, req_chan.sample_b}) - $signed({b_ref_ff[9], b_ref_ff});
      prod_a = dev_a * dev_a;
      prod_b = dev_b * dev_b;
   end

   // The result buffer is free for a new frame once its last word leaves.
   assign snap_free      = !busy_ff || (rsp_chan.ready && cnt_ff == CH_D);
   assign step.advance   = s1_valid_ff && (!s1_end_ff || snap_free);
   assign step.frame_end = s1_end_ff;
   assign step.take      = idx_ff < IDX_W'(FRAME_MAX);
   assign step.first     = idx_ff == '0;
   assign step.track     = step.take && (int'(idx_ff) >= WIN_FIRST) && (int'(idx_ff) < WIN_END);
   assign idx12          = 12'(idx_ff);

   assign req_chan.ready = !s1_valid_ff || step.advance;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = busy_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_a_ff     <= req_chan.sample_a;
         s1_b_ff     <= req_chan.sample_b;
         s1_logic_ff <= req_chan.logic_bits;
         s1_end_ff   <= req_chan.frame_end;
         s1_sq_a_ff  <= 20'(prod_a);
         s1_sq_b_ff  <= 20'(prod_b);
      end
   end

   // The index stops at the frame limit; later words are not measured.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (step.advance) begin
         if (s1_end_ff) begin
            idx_ff <= '0;
         end else if (step.take) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   assign ana_sample[0] = s1_a_ff;
   assign ana_sample[1] = s1_b_ff;
   assign ana_square[0] = s1_sq_a_ff;
   assign ana_square[1] = s1_sq_b_ff;

   for (genvar c = 0; c < 2; c++) begin : g_analog
      scm_analog u_analog (
         .clock      (clock),
         .reset      (reset),
         .step       (step),
         .sample     (ana_sample[c]),
         .square     (ana_square[c]),
         .is_high    (ch_high[c]),
         .is_low     (ch_low[c]),
         .frame_stat (ana_stat[c])
      );
   end

   // Logic channels have no hysteresis: a clear bit counts as low.
   for (genvar c = 0; c < 2; c++) begin : g_logic_level
      assign ch_high[c + 2] = s1_logic_ff[c];
      assign ch_low[c + 2]  = !s1_logic_ff[c];
   end

   for (genvar c = 0; c < 4; c++) begin : g_pulse
      scm_pulse u_pulse (
         .clock      (clock),
         .reset      (reset),
         .step       (step),
         .idx        (idx12),
         .is_high    (ch_high[c]),
         .is_low     (ch_low[c]),
         .frame_stat (pulse_stat[c])
      );
   end

   // Result words of the frame, including the word that closes it.
   for (genvar c = 0; c < 4; c++) begin : g_snap
      if (c < 2) begin : g_ana
         assign snap_in[c] = '{
            channel:      2'(c),
            max_value:    ana_stat[c].max_value,
            min_value:    ana_stat[c].min_value,
            sample_sum:   ana_stat[c].sample_sum,
            square_sum:   ana_stat[c].square_sum,
            edge_span:    pulse_stat[c].edge_span,
            high_time:    pulse_stat[c].high_time,
            rising_edges: pulse_stat[c].rising_edges,
            last_of_run:  1'b0
         };
      end else begin : g_dig
         assign snap_in[c] = '{
            channel:      2'(c),
            max_value:    '0,
            min_value:    '0,
            sample_sum:   '0,
            square_sum:   '0,
            edge_span:    pulse_stat[c].edge_span,
            high_time:    pulse_stat[c].high_time,
            rising_edges: pulse_stat[c].rising_edges,
            last_of_run:  (2'(c) == CH_D)
         };
      end
   end

   always_ff @(posedge clock) begin
      if (step.advance && s1_end_ff) begin
         snap_ff <= snap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= CH_A;
      end else if (step.advance && s1_end_ff) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CH_A;
      end else if (rsp_fire) begin
         if (cnt_ff == CH_D) begin
            busy_ff <= 1'b0;
         end
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

   assign rsp_chan.valid        = busy_ff;
   assign rsp_chan.channel      = snap_ff[cnt_ff].channel;
   assign rsp_chan.max_value    = snap_ff[cnt_ff].max_value;
   assign rsp_chan.min_value    = snap_ff[cnt_ff].min_value;
   assign rsp_chan.sample_sum   = snap_ff[cnt_ff].sample_sum;
   assign rsp_chan.square_sum   = snap_ff[cnt_ff].square_sum;
   assign rsp_chan.edge_span    = snap_ff[cnt_ff].edge_span;
   assign rsp_chan.high_time    = snap_ff[cnt_ff].high_time;
   assign rsp_chan.rising_edges = snap_ff[cnt_ff].rising_edges;
   assign rsp_chan.last_of_run  = snap_ff[cnt_ff].last_of_run;

endmodule

`default_nettype wire

/* rtl/scm_analog.sv */
// Statistics and hysteresis thresholds of one analog channel.
// Depends on scm_pkg.
`default_nettype none

module scm_analog
   import scm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  step_type     step,
   input  logic [7:0]   sample,
   input  logic [19:0]  square,
   output logic         is_high,
   output logic         is_low,
   output ana_stat_type frame_stat
);

   ana_stat_type stat_ff, stat_in;
   logic [7:0]   upper_ff, lower_ff, upper_in;
   logic [20:0]  sum_wide;
   logic [32:0]  sq_wide;
   logic [8:0]   mid_sum;

   always_comb begin
      is_high  = sample > upper_ff;
      is_low   = sample < lower_ff;
      stat_in  = stat_ff;
      sum_wide = {1'b0, stat_ff.sample_sum} + {13'd0, sample};
      sq_wide  = {1'b0, stat_ff.square_sum} + {13'd0, square};
      if (step.take) begin
         if (step.first) begin
            stat_in.max_value = sample;
            stat_in.min_value = sample;
         end else begin
            if (sample > stat_ff.max_value) stat_in.max_value = sample;
            if (sample < stat_ff.min_value) stat_in.min_value = sample;
         end
         stat_in.sample_sum = sum_wide[20] ? '1 : sum_wide[19:0];
         stat_in.square_sum = sq_wide[32] ? '1 : sq_wide[31:0];
      end
      // New thresholds come from the extremes including this word.
      mid_sum  = {1'b0, stat_in.max_value} + {1'b0, stat_in.min_value};
      upper_in = HYST_UP + mid_sum[8:1];
   end

   assign frame_stat = stat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff  <= '0;
         upper_ff <= '0;
         lower_ff <= '0;
      end else if (step.advance) begin
         if (step.frame_end) begin
            stat_ff  <= '0;
            upper_ff <= upper_in;
            lower_ff <= upper_in - HYST_DOWN;
         end else begin
            stat_ff <= stat_in;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/scm_pulse.sv */
// Pulse tracker of one channel: rising edges, edge span and high time.
// Depends on scm_pkg.
`default_nettype none

module scm_pulse
   import scm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  step_type       step,
   input  logic [11:0]    idx,
   input  logic           is_high,
   input  logic           is_low,
   output pulse_stat_type frame_stat
);

   typedef enum logic [1:0] {
      PH_LOW  = 2'd0,
      PH_HIGH = 2'd1,
      PH_WAIT = 2'd2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [11:0] rise_ff, rise_in, first_ff, first_in, high_ff, high_in;
   logic [10:0] edge_ff, edge_in;

   always_comb begin
      phase_in = phase_ff;
      rise_in  = rise_ff;
      first_in = first_ff;
      high_in  = high_ff;
      edge_in  = edge_ff;
      if (step.track) begin
         // Until the first high every measured index restarts the span.
         if (phase_ff == PH_WAIT) begin
            rise_in  = idx;
            first_in = idx;
            high_in  = '0;
         end
         priority if (is_high) begin
            if (phase_ff == PH_LOW) begin
               rise_in = idx;
               edge_in = edge_ff + 11'd1;
            end
            phase_in = PH_HIGH;
         end else if (is_low && phase_ff == PH_HIGH) begin
            phase_in = PH_LOW;
            high_in  = high_ff + idx - rise_in;
         end else begin
            // Between the thresholds the phase holds.
            phase_in = phase_ff;
         end
      end
      frame_stat.edge_span    = rise_in - first_in;
      frame_stat.high_time    = high_in;
      frame_stat.rising_edges = edge_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         rise_ff  <= '0;
         first_ff <= '0;
         high_ff  <= '0;
         edge_ff  <= '0;
      end else if (step.advance) begin
         if (step.frame_end) begin
            phase_ff <= PH_WAIT;
            rise_ff  <= '0;
            first_ff <= '0;
            high_ff  <= '0;
            edge_ff  <= '0;
         end else begin
            phase_ff <= phase_in;
            rise_ff  <= rise_in;
            first_ff <= first_in;
            high_ff  <= high_in;
            edge_ff  <= edge_in;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/scm_checker.sv */
// Port-level checks of the scope frame measurement result channel, and their binding.
// Depends on scm_pkg and scope_frame_measurement.
`default_nettype none

module scm_checker
   import scm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_channel,
   input  logic [7:0]  rsp_max_value,
   input  logic [7:0]  rsp_min_value,
   input  logic [19:0] rsp_sample_sum,
   input  logic [31:0] rsp_square_sum,
   input  logic        rsp_last_of_run
);

   // Nothing is offered straight after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Only the channel D word closes a run.
   a_last_marks_d: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_run == (rsp_channel == CH_D)))
      else $error("last_of_run does not match channel D");

   // The four words of a frame follow each other without a gap.
   a_channel_sequence: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_channel != CH_D) |=>
         (rsp_valid && rsp_channel == $past(rsp_channel) + 2'd1))
      else $error("result channel sequence broken");

   // Logic channels carry no analog statistics.
   a_logic_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_channel == CH_C || rsp_channel == CH_D)) |->
         (rsp_max_value == '0 && rsp_min_value == '0 &&
          rsp_sample_sum == '0 && rsp_square_sum == '0))
      else $error("analog statistics on a logic channel");

endmodule

bind scope_frame_measurement scm_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_channel     (rsp_chan.channel),
   .rsp_max_value   (rsp_chan.max_value),
   .rsp_min_value   (rsp_chan.min_value),
   .rsp_sample_sum  (rsp_chan.sample_sum),
   .rsp_square_sum  (rsp_chan.square_sum),
   .rsp_last_of_run (rsp_chan.last_of_run)
);

`default_nettype wire
